/* rtl/pidc_pkg.sv */
// Shared definitions for the PID controller step block: field widths,
// op codes, register indexes and the output-limit clamp.
// Depends on nothing; used by the top level, its checker and the testbench.
`timescale 1ns / 1ps

package pidc_pkg;

   localparam int unsigned MEAS_W    = 32;             // Q16.16 measurement
   localparam int unsigned LIMIT_W   = 16;             // integer limits / drive
   localparam int unsigned FRAC_W    = 16;             // fraction bits
   localparam int unsigned DIFF_W    = MEAS_W + 1;     // exact error / delta
   localparam int unsigned GAIN_W    = MEAS_W + 1;     // gain after reverse
   localparam int unsigned PROD_W    = DIFF_W + GAIN_W;
   localparam int unsigned TERM_W    = 49;             // product >> 16
   localparam int unsigned INTEG_W   = 33;             // Q17.16 integral
   localparam int unsigned SUM_W     = 51;             // widest pre-clamp sum
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_MANUAL = 2'd1;
   localparam logic [1:0] OP_AUTO   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE  = 3'd6;

   // Upper limit first, then lower; crossed limits resolve the same way.
   function automatic logic signed [INTEG_W-1:0] clamp_limits(
      input logic signed [SUM_W-1:0] v,
      input logic [LIMIT_W-1:0]      lo,
      input logic [LIMIT_W-1:0]      hi
   );
      logic signed [SUM_W-1:0] hi_v;
      logic signed [SUM_W-1:0] lo_v;
      logic signed [INTEG_W-1:0] res;
      hi_v = $signed({{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, hi, {FRAC_W{1'b0}}});
      lo_v = $signed({{(SUM_W-LIMIT_W-FRAC_W){1'b0}}, lo, {FRAC_W{1'b0}}});
      if (v > hi_v) begin
         res = hi_v[INTEG_W-1:0];
      end else if (v < lo_v) begin
         res = lo_v[INTEG_W-1:0];
      end else begin
         res = v[INTEG_W-1:0];
      end
      return res;
   endfunction

endpackage

/* rtl/pid_controller_step.sv */
// PID controller step, derivative on measurement, signed Q16.16.
// Pipe: a sample beat passes s1, s2 and s3 before its drive beat is registered.
// Throughput: one beat per cycle unless held; integral add/clamp is combinational.
// Stalls: a held result freezes the whole pipe and req_ready drops with it.
// Reset (synchronous, active high): registers to defaults, auto mode on,
// integral and last measurement zero, pipe empty.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pid_controller_step (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic signed [pidc_pkg::MEAS_W-1:0] req_measurement,
   input  logic [pidc_pkg::LIMIT_W-1:0]       req_present_output,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pidc_pkg::LIMIT_W-1:0]       rsp_drive,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidc_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam int unsigned MW = pidc_pkg::MEAS_W;
   localparam int unsigned LW = pidc_pkg::LIMIT_W;
   localparam int unsigned FW = pidc_pkg::FRAC_W;
   localparam int unsigned DW = pidc_pkg::DIFF_W;
   localparam int unsigned GW = pidc_pkg::GAIN_W;
   localparam int unsigned PW = pidc_pkg::PROD_W;
   localparam int unsigned TW = pidc_pkg::TERM_W;
   localparam int unsigned IW = pidc_pkg::INTEG_W;
   localparam int unsigned SW = pidc_pkg::SUM_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [MW-1:0] setpoint_ff;
   logic signed [MW-1:0] gain_p_ff;
   logic signed [MW-1:0] gain_i_ff;
   logic signed [MW-1:0] gain_d_ff;
   logic [LW-1:0]        out_min_ff;
   logic [LW-1:0]        out_max_ff;
   logic                 reverse_ff;
   logic                 reclamp_ff;   // a limit changed last cycle in auto mode

   // ---------------------------------------------------------------
   // Controller state
   // ---------------------------------------------------------------
   logic                 auto_ff;      // mode as seen by the next request beat
   logic signed [MW-1:0] prev_meas_ff;
   logic signed [IW-1:0] integ_ff, integ_in;

   // ---------------------------------------------------------------
   // Pipe registers
   // ---------------------------------------------------------------
   logic                 s1_valid_ff, s1_seed_ff;
   logic signed [DW-1:0] s1_err_ff, s1_dmeas_ff;
   logic [LW-1:0]        s1_seed_val_ff;

   logic                 s2_valid_ff, s2_seed_ff;
   logic signed [TW-1:0] s2_term_p_ff, s2_term_i_ff, s2_term_d_ff;
   logic [LW-1:0]        s2_seed_val_ff;

   logic                 s3_valid_ff;
   logic signed [TW:0]   s3_pd_ff;     // proportional minus derivative

   logic                 rsp_valid_ff;
   logic [LW-1:0]        rsp_drive_ff;

   // ---------------------------------------------------------------
   // Handshakes: the pipe moves unless a result beat is held
   // ---------------------------------------------------------------
   logic advance;
   logic req_take;
   logic csr_take;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_take  = req_valid && advance;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // ---------------------------------------------------------------
   // Front stage: decode op, track mode and last measurement
   // ---------------------------------------------------------------
   logic                 take_sample, take_seed;
   logic signed [DW-1:0] err_in, dmeas_in;

   assign take_sample = req_take && (req_op == pidc_pkg::OP_SAMPLE) && auto_ff;
   assign take_seed   = req_take && (req_op == pidc_pkg::OP_AUTO) && !auto_ff;
   assign err_in   = $signed({setpoint_ff[MW-1], setpoint_ff})
                   - $signed({req_measurement[MW-1], req_measurement});
   assign dmeas_in = $signed({req_measurement[MW-1], req_measurement})
                   - $signed({prev_meas_ff[MW-1], prev_meas_ff});

   // ---------------------------------------------------------------
   // Multiply stage: effective gains and the three products
   // ---------------------------------------------------------------
   logic signed [GW-1:0] eff_p, eff_i, eff_d;
   logic signed [PW-1:0] prod_p, prod_i, prod_d;

   // Sign-extend, then negate for a reverse-acting loop (-2^31 becomes +2^31).
   assign eff_p = reverse_ff ? -$signed({gain_p_ff[MW-1], gain_p_ff})
                             :  $signed({gain_p_ff[MW-1], gain_p_ff});
   assign eff_i = reverse_ff ? -$signed({gain_i_ff[MW-1], gain_i_ff})
                             :  $signed({gain_i_ff[MW-1], gain_i_ff});
   assign eff_d = reverse_ff ? -$signed({gain_d_ff[MW-1], gain_d_ff})
                             :  $signed({gain_d_ff[MW-1], gain_d_ff});
   assign prod_p = s1_err_ff * eff_p;
   assign prod_i = s1_err_ff * eff_i;
   assign prod_d = s1_dmeas_ff * eff_d;

   // ---------------------------------------------------------------
   // Integral stage: seed, accumulate or re-clamp
   // ---------------------------------------------------------------
   logic signed [SW-1:0] integ_sum;
   logic signed [SW-1:0] seed_wide;
   logic signed [SW-1:0] drive_sum;
   logic signed [IW-1:0] drive_clamped;

   assign integ_sum = $signed({{(SW-IW){integ_ff[IW-1]}}, integ_ff})
                    + $signed({{(SW-TW){s2_term_i_ff[TW-1]}}, s2_term_i_ff});
   assign seed_wide = $signed({{(SW-LW-FW){1'b0}}, s2_seed_val_ff, {FW{1'b0}}});

   always_comb begin
      integ_in = integ_ff;
      if (advance && s2_valid_ff) begin
         if (s2_seed_ff) begin
            integ_in = pidc_pkg::clamp_limits(seed_wide, out_min_ff, out_max_ff);
         end else begin
            integ_in = pidc_pkg::clamp_limits(integ_sum, out_min_ff, out_max_ff);
         end
      end else if (reclamp_ff) begin
         integ_in = pidc_pkg::clamp_limits(
            $signed({{(SW-IW){integ_ff[IW-1]}}, integ_ff}), out_min_ff, out_max_ff);
      end
   end

   // ---------------------------------------------------------------
   // Output stage: integral already holds this sample's value
   // ---------------------------------------------------------------
   assign drive_sum = $signed({{(SW-IW){integ_ff[IW-1]}}, integ_ff})
                    + $signed({{(SW-TW-1){s3_pd_ff[TW]}}, s3_pd_ff});
   assign drive_clamped = pidc_pkg::clamp_limits(drive_sum, out_min_ff, out_max_ff);

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= '0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         out_min_ff   <= '0;
         out_max_ff   <= '1;
         reverse_ff   <= 1'b0;
         reclamp_ff   <= 1'b0;
         auto_ff      <= 1'b1;
         prev_meas_ff <= '0;
         integ_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integ_ff   <= integ_in;
         reclamp_ff <= 1'b0;
         if (csr_take) begin
            case (csr_index)
               pidc_pkg::REG_SETPOINT: setpoint_ff <= $signed(csr_data[MW-1:0]);
               pidc_pkg::REG_GAIN_P:   gain_p_ff   <= $signed(csr_data[MW-1:0]);
               pidc_pkg::REG_GAIN_I:   gain_i_ff   <= $signed(csr_data[MW-1:0]);
               pidc_pkg::REG_GAIN_D:   gain_d_ff   <= $signed(csr_data[MW-1:0]);
               pidc_pkg::REG_OUT_MIN: begin
                  out_min_ff <= csr_data[LW-1:0];
                  reclamp_ff <= auto_ff;
               end
               pidc_pkg::REG_OUT_MAX: begin
                  out_max_ff <= csr_data[LW-1:0];
                  reclamp_ff <= auto_ff;
               end
               pidc_pkg::REG_REVERSE:  reverse_ff  <= csr_data[0];
               default: ;  // drop writes to unmapped indexes
            endcase
         end

         // Mode follows the request order; manual mode stops sample beats.
         if (req_take && (req_op == pidc_pkg::OP_MANUAL)) begin
            auto_ff <= 1'b0;
         end else if (take_seed) begin
            auto_ff <= 1'b1;
         end
         if (take_sample || take_seed) begin
            prev_meas_ff <= req_measurement;
         end

         if (advance) begin
            s1_valid_ff  <= take_sample || take_seed;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff && !s2_seed_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_seed_ff     <= take_seed;
         s1_err_ff      <= err_in;
         s1_dmeas_ff    <= dmeas_in;
         s1_seed_val_ff <= req_present_output;

         // floor(product / 2^16) is an arithmetic shift of the exact product
         s2_seed_ff     <= s1_seed_ff;
         s2_term_p_ff   <= prod_p[FW+TW-1:FW];
         s2_term_i_ff   <= prod_i[FW+TW-1:FW];
         s2_term_d_ff   <= prod_d[FW+TW-1:FW];
         s2_seed_val_ff <= s1_seed_val_ff;

         s3_pd_ff <= $signed({s2_term_p_ff[TW-1], s2_term_p_ff})
                   - $signed({s2_term_d_ff[TW-1], s2_term_d_ff});

         rsp_drive_ff <= drive_clamped[FW+LW-1:FW];
      end
   end

endmodule

/* rtl/pidc_checker.sv */
// Port-level checks for the PID controller step block, bound to the top level.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_op,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pidc_pkg::LIMIT_W-1:0] rsp_drive
);

   // A held result beat keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("result beat changed while stalled");

   // With no result waiting, the pipe must take requests.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with output empty");

   // With the output empty for a while, a new result came from an accepted
   // sample beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && $past(!rsp_valid, 2) && $past(!rsp_valid, 3)
         && $past(!rsp_valid, 4)
      |-> $past(req_valid && req_ready && (req_op == pidc_pkg::OP_SAMPLE), 4))
      else $error("result without matching sample beat");

   // Reset empties the output.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_op    (req_op),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive)
);

/* tb/pidc_drive_checker.sv */
// Drive checker for pid_controller_step: tracks register writes and request
// beats, predicts each drive beat and compares it with the result channel.
// Depends on pidc_pkg for widths, op codes and register indexes.
`timescale 1ns / 1ps

module pidc_drive_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic signed [pidc_pkg::MEAS_W-1:0] req_measurement,
   input  logic [pidc_pkg::LIMIT_W-1:0]       req_present_output,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [pidc_pkg::LIMIT_W-1:0]       rsp_drive,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidc_pkg::CSR_DAT_W-1:0]     csr_data,
   output int                                 mismatches,
   output int                                 drives_pending,
   output int                                 drives_compared
);
   import pidc_pkg::*;

   // Loop settings as last written.
   logic signed [MEAS_W-1:0]    setpoint_q;
   logic signed [CSR_DAT_W-1:0] kp_q;
   logic signed [CSR_DAT_W-1:0] ki_q;
   logic signed [CSR_DAT_W-1:0] kd_q;
   logic [LIMIT_W-1:0]          lim_lo;
   logic [LIMIT_W-1:0]          lim_hi;
   logic                        reverse_q;

   // Loop state, kept wide enough that no intermediate sum can wrap.
   longint                      integ_acc;
   logic signed [MEAS_W-1:0]    last_meas;
   logic                        auto_on;

   logic [LIMIT_W-1:0]          drive_due[$];
   logic [LIMIT_W-1:0]          want;
   int                          n_fail;
   int                          n_compared;

   task automatic report_mismatch(input string what);
      $display("[%0t] drive check: %s", $time, what);
      n_fail++;
   endtask

   // Upper limit wins, so crossed limits still give a value between them.
   function automatic longint clip_to_limits(input longint v);
      longint hi;
      longint lo;
      hi = longint'(lim_hi) << FRAC_W;
      lo = longint'(lim_lo) << FRAC_W;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint signed_gain(input logic signed [CSR_DAT_W-1:0] g);
      longint s;
      s = longint'(g);
      return reverse_q ? -s : s;
   endfunction

   // Exact product, then floor to Q16.16.
   function automatic longint q16_mul(input longint a, input longint b);
      return (a * b) >>> FRAC_W;
   endfunction

   task automatic load_register(input logic [CSR_IDX_W-1:0] idx,
                                input logic [CSR_DAT_W-1:0] data);
      case (idx)
         REG_SETPOINT: setpoint_q = data;
         REG_GAIN_P:   kp_q = data;
         REG_GAIN_I:   ki_q = data;
         REG_GAIN_D:   kd_q = data;
         REG_OUT_MIN: begin
            lim_lo = data[LIMIT_W-1:0];
            if (auto_on) integ_acc = clip_to_limits(integ_acc);
         end
         REG_OUT_MAX: begin
            lim_hi = data[LIMIT_W-1:0];
            if (auto_on) integ_acc = clip_to_limits(integ_acc);
         end
         REG_REVERSE:  reverse_q = data[0];
         default: ;
      endcase
   endtask

   task automatic step_loop(input logic [1:0]                op,
                            input logic signed [MEAS_W-1:0]  meas,
                            input logic [LIMIT_W-1:0]        seed);
      longint err;
      longint dmeas;
      longint y;
      case (op)
         OP_MANUAL: auto_on = 1'b0;
         OP_AUTO: begin
            if (!auto_on) begin
               integ_acc = clip_to_limits(longint'(seed) << FRAC_W);
               last_meas = meas;
               auto_on   = 1'b1;
            end
         end
         OP_SAMPLE: begin
            if (auto_on) begin
               err   = longint'(setpoint_q) - longint'(meas);
               dmeas = longint'(meas) - longint'(last_meas);
               integ_acc = clip_to_limits(integ_acc + q16_mul(err, signed_gain(ki_q)));
               y = q16_mul(err, signed_gain(kp_q)) + integ_acc
                   - q16_mul(dmeas, signed_gain(kd_q));
               y = clip_to_limits(y);
               last_meas = meas;
               drive_due.push_back(y[FRAC_W +: LIMIT_W]);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         setpoint_q = '0;
         kp_q       = '0;
         ki_q       = '0;
         kd_q       = '0;
         lim_lo     = '0;
         lim_hi     = '1;
         reverse_q  = 1'b0;
         integ_acc  = 0;
         last_meas  = '0;
         auto_on    = 1'b1;
         drive_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_due.size() == 0) begin
               report_mismatch($sformatf("drive beat %0d with none expected", rsp_drive));
            end else begin
               want = drive_due.pop_front();
               n_compared++;
               if (rsp_drive !== want)
                  report_mismatch($sformatf("drive %0d, expected %0d", rsp_drive, want));
            end
         end
         if (csr_valid && csr_ready) load_register(csr_index, csr_data);
         if (req_valid && req_ready)
            step_loop(req_op, req_measurement, req_present_output);
      end
      mismatches      <= n_fail;
      drives_pending  <= drive_due.size();
      drives_compared <= n_compared;
   end

endmodule

/* tb/tb_top.sv */
// Top of the pid_controller_step testbench: clock, reset, request and
// register stimulus, result back-pressure, and the verdict.
// Depends on pidc_pkg, pid_controller_step and pidc_drive_checker.
`timescale 1ns / 1ps

module tb_top;
   import pidc_pkg::*;

   localparam logic [1:0]           OP_UNUSED     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NONE      = 3'd7;
   localparam int                   CYCLE_LIMIT   = 1_000_000;
   localparam int                   SETTLE_CYCLES = 8;    // pipe is 4 deep, leave margin
   localparam int                   RANDOM_PHASES = 12;
   localparam int                   PHASE_BEATS   = 125;
   localparam int                   SQUEEZE_AT    = 700;  // request beats before the long hold
   localparam int                   SQUEEZE_LEN   = 500;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_op;
   logic signed [MEAS_W-1:0]    req_measurement;
   logic [LIMIT_W-1:0]          req_present_output;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [LIMIT_W-1:0]          rsp_drive;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DAT_W-1:0]        csr_data;

   int                          mismatches;
   int                          drives_pending;
   int                          drives_compared;
   int                          beats_sent;
   int                          reg_writes;
   int                          cycle_count;
   bit                          no_gaps;      // phase runs back to back on the request side
   logic signed [MEAS_W-1:0]    target;       // last setpoint written; measurements aim near it

   pid_controller_step uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_measurement    (req_measurement),
      .req_present_output (req_present_output),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive          (rsp_drive),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   pidc_drive_checker drive_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_measurement    (req_measurement),
      .req_present_output (req_present_output),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive          (rsp_drive),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatches         (mismatches),
      .drives_pending     (drives_pending),
      .drives_compared    (drives_compared)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: abort a hung run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d drive beats still due",
               cycle_count, drives_pending);
      $display("Simulation FAILED");
      $finish;
   end

   // Pause length: mostly none or short, now and then a long one.
   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Gains: mostly modest values around +/-4.0, sometimes any bit pattern,
   // sometimes an extreme (most negative, most positive, zero).
   function automatic logic [CSR_DAT_W-1:0] pick_gain();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 32'($urandom_range(0, 32'h0007_FFFF)) - 32'h0004_0000;
      if (r < 85) return $urandom();
      if (r < 90) return 32'h8000_0000;
      if (r < 95) return 32'h7FFF_FFFF;
      return 32'h0000_0000;
   endfunction

   // Offer one request beat after a random pause; hold it until accepted.
   // Valid stays high into the next beat when no pause follows.
   task automatic send_beat(input logic [1:0]               op,
                            input logic signed [MEAS_W-1:0] meas,
                            input logic [LIMIT_W-1:0]       seed);
      int gap;
      gap = no_gaps ? 0 : random_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_measurement    <= meas;
      req_present_output <= seed;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Present one register write and hold it until accepted. The caller
   // drops csr_valid after the last write of a batch.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
   endtask

   // Drop the request side, wait out every due drive beat, then let beats
   // that make no result leave the pipe before any register changes.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_random_setting(input bit every_reg);
      logic [LIMIT_W-1:0] a;
      logic [LIMIT_W-1:0] b;
      logic [LIMIT_W-1:0] lo;
      logic [LIMIT_W-1:0] hi;
      int                 r;
      if (every_reg || $urandom_range(0, 1)) begin
         r = $urandom_range(0, 99);
         if (r < 70)      target = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
         else if (r < 88) target = $urandom();
         else if (r < 94) target = 32'h7FFF_FFFF;
         else             target = 32'h8000_0000;
         write_reg(REG_SETPOINT, target);
      end
      if (every_reg || $urandom_range(0, 1)) write_reg(REG_GAIN_P, pick_gain());
      if (every_reg || $urandom_range(0, 1)) write_reg(REG_GAIN_I, pick_gain());
      if (every_reg || $urandom_range(0, 1)) write_reg(REG_GAIN_D, pick_gain());
      if (every_reg || $urandom_range(0, 1)) begin
         a = 16'($urandom_range(0, 65535));
         b = 16'($urandom_range(0, 65535));
         r = $urandom_range(0, 99);
         if (r < 8) begin
            // crossed on purpose
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
         end else if (r < 14) begin
            lo = '0;
            hi = '1;
         end else begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
         end
         // Order matters for the integral re-clamp; vary it.
         if ($urandom_range(0, 1)) begin
            write_reg(REG_OUT_MIN, 32'(lo));
            write_reg(REG_OUT_MAX, 32'(hi));
         end else begin
            write_reg(REG_OUT_MAX, 32'(hi));
            write_reg(REG_OUT_MIN, 32'(lo));
         end
      end
      if (every_reg || $urandom_range(0, 1)) write_reg(REG_REVERSE, 32'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, $urandom());
      csr_valid <= 1'b0;
   endtask

   // Result side: random ready/stall stretches, plus one long hold while
   // requests keep coming so the pipe fills and req_ready drops.
   initial begin : result_sink
      int n;
      bit squeezed;
      squeezed = 1'b0;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!squeezed && beats_sent >= SQUEEZE_AT) begin
            squeezed = 1'b1;
            rsp_ready <= 1'b0;
            for (n = 0; n < SQUEEZE_LEN; n++) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (1 + random_gap()) @(posedge clock);
         n = random_gap();
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int                       r;
      logic [1:0]               op;
      logic signed [MEAS_W-1:0] meas;

      beats_sent = 0;
      reg_writes = 0;
      no_gaps    = 1'b0;
      target     = '0;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_op             <= OP_SAMPLE;
      req_measurement    <= '0;
      req_present_output <= '0;
      csr_valid          <= 1'b0;
      csr_index          <= REG_SETPOINT;
      csr_data           <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings have zero gains: the first sample must give drive 0.
      send_beat(OP_SAMPLE, 32'h0000_0000, 16'h0000);
      settle();

      // Plain direct-acting loop with a narrow output range.
      target = 32'h0010_0000;
      write_reg(REG_SETPOINT, target);
      write_reg(REG_GAIN_P,   32'h0001_0000);
      write_reg(REG_GAIN_I,   32'h0000_4000);
      write_reg(REG_GAIN_D,   32'h0000_8000);
      write_reg(REG_OUT_MIN,  32'd0);
      write_reg(REG_OUT_MAX,  32'd1000);
      write_reg(REG_REVERSE,  32'd0);
      csr_valid <= 1'b0;
      send_beat(OP_SAMPLE, 32'h7FFF_FFFF, 16'hFFFF);  // measurement extremes
      send_beat(OP_SAMPLE, 32'h8000_0000, 16'h0000);
      send_beat(OP_SAMPLE, 32'h000F_8000, 16'h1234);
      send_beat(OP_SAMPLE, target, 16'h0000);          // zero error
      send_beat(OP_UNUSED, 32'hDEAD_BEEF, 16'hFFFF);   // ignored op
      send_beat(OP_AUTO, 32'h0123_4567, 16'hFFFF);     // already auto: no effect
      send_beat(OP_MANUAL, 32'h0000_0000, 16'h0000);
      send_beat(OP_SAMPLE, 32'h0005_0000, 16'h0000);   // frozen: no drive beat
      send_beat(OP_AUTO, 32'h0008_0000, 16'hFFFF);     // seed clips to out_max
      send_beat(OP_SAMPLE, 32'h0009_0000, 16'h0000);
      send_beat(OP_MANUAL, 32'h0000_0000, 16'h0000);
      send_beat(OP_AUTO, 32'hFFFF_FFFF, 16'h0000);     // seed at zero
      send_beat(OP_SAMPLE, 32'hFFFF_0000, 16'h0000);
      settle();

      // Tighten the limits in auto mode: the integral is pulled in at once.
      write_reg(REG_OUT_MAX, 32'd10);
      write_reg(REG_OUT_MIN, 32'd5);
      csr_valid <= 1'b0;
      send_beat(OP_SAMPLE, 32'h0010_0000, 16'h0000);
      send_beat(OP_SAMPLE, 32'h0020_0000, 16'h0000);
      send_beat(OP_MANUAL, 32'h0000_0000, 16'h0000);
      settle();

      // Manual now, so these limit writes leave the integral alone.
      // Crossed limits, reverse action, most negative P and I gains, most positive D gain, top setpoint.
      write_reg(REG_OUT_MIN,  32'd60000);
      write_reg(REG_OUT_MAX,  32'd100);
      write_reg(REG_REVERSE,  32'd1);
      write_reg(REG_GAIN_P,   32'h8000_0000);
      write_reg(REG_GAIN_I,   32'h8000_0000);
      write_reg(REG_GAIN_D,   32'h7FFF_FFFF);
      target = 32'h7FFF_FFFF;
      write_reg(REG_SETPOINT, target);
      write_reg(REG_NONE,     32'hFFFF_FFFF);          // no such register
      csr_valid <= 1'b0;
      send_beat(OP_AUTO,   32'h0000_0000, 16'd500);
      send_beat(OP_SAMPLE, 32'h8000_0000, 16'h0000);
      send_beat(OP_SAMPLE, 32'h7FFF_FFFF, 16'h0000);
      send_beat(OP_SAMPLE, 32'h0000_0000, 16'h0000);
      settle();

      // Bottom setpoint, both limits at the top of their range.
      target = 32'h8000_0000;
      write_reg(REG_SETPOINT, target);
      write_reg(REG_OUT_MAX,  32'd65535);
      write_reg(REG_OUT_MIN,  32'd65535);
      write_reg(REG_REVERSE,  32'd0);
      csr_valid <= 1'b0;
      send_beat(OP_SAMPLE, 32'h8000_0000, 16'h0000);
      send_beat(OP_SAMPLE, 32'h0000_0000, 16'h0000);

      // Random phases: new settings, then mostly samples near the setpoint
      // with mode changes mixed in; some phases run with no request pauses.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         settle();
         write_random_setting(ph == 0);
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 82)      op = OP_SAMPLE;
            else if (r < 88) op = OP_MANUAL;
            else if (r < 97) op = OP_AUTO;
            else             op = OP_UNUSED;
            if ($urandom_range(0, 9) < 7)
               meas = target + 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
            else
               meas = $urandom();
            send_beat(op, meas, 16'($urandom_range(0, 65535)));
         end
      end
      settle();

      $display("Run covered %0d request beats over all ops and both modes, %0d register writes",
               beats_sent, reg_writes);
      $display("%0d drive beats compared, %0d mismatches", drives_compared, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* pid_controller_step.f */
rtl/pidc_pkg.sv
rtl/pid_controller_step.sv
rtl/pidc_checker.sv
tb/pidc_drive_checker.sv
tb/tb_top.sv
